### rtl/o1re_pkg.sv
// Shared constants and types for the order-1 range encoder.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package o1re_pkg;

	localparam int CONTEXTS    = 256;
	localparam int CTX_BITS    = $clog2(CONTEXTS);
	localparam int SYMBOLS     = 256;
	localparam int SYM_BITS    = 8;
	localparam int ADDR_W      = CTX_BITS + SYM_BITS;
	localparam int CNT_W       = 25;
	localparam int FLUSH_BYTES = 5;
	localparam int FCNT_W      = 3;

	localparam logic [CNT_W-1:0] TOT_RESET = CNT_W'(256);
	localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
	localparam logic [7:0]       BYTE_FF   = 8'hFF;
	localparam logic [7:0]       BYTE_00   = 8'h00;
	localparam logic [31:0]      WORD_FF   = 32'hFFFF_FFFF;

	// datapath operations issued by the controller
	typedef enum logic [4:0] {
		OP_NONE,
		OP_START,
		OP_WALK,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_MUL1,
		OP_MUL2,
		OP_CARRY_A,
		OP_CARRY_B,
		OP_NORM_FF,
		OP_EMIT_H,
		OP_EMIT_P,
		OP_INC,
		OP_HALVE,
		OP_HALVE_END,
		OP_TAIL,
		OP_FINISH
	} op_t;

	typedef struct packed {
		op_t op;
	} ctl_t;

	typedef struct packed {
		logic sweep_last;
		logic div_last;
		logic range_small;
		logic top_ff;
		logic carry;
		logic held_v;
		logic pend_nz;
		logic pend_gt1;
		logic halve;
		logic eom;
		logic push_ok;
	} sts_t;

endpackage
`default_nettype wire

### rtl/o1re_sym_if.sv
// Input channel: one message byte per beat, with the end-of-message mark.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface o1re_sym_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_message;

	modport source (output valid, output data_byte, output end_of_message, input ready);
	modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface
`default_nettype wire

### rtl/o1re_run_if.sv
// Output channel: one run of identical coded bytes per beat.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface o1re_run_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic [31:0] repeat_count;
	logic        last_of_run;
	logic        stream_done;

	modport source (output valid, output out_byte, output repeat_count,
		output last_of_run, output stream_done, input ready);
	modport sink   (input valid, input out_byte, input repeat_count,
		input last_of_run, input stream_done, output ready);
endinterface
`default_nettype wire

### rtl/order1_range_encoder.sv
// Top level of the order-1 adaptive range encoder.
// Joins o1re_ctrl and o1re_dp; uses o1re_pkg, o1re_sym_if, o1re_run_if.
// Usage:
//   symbols: one message byte per beat (data_byte, end_of_message).
//   runs:    one run per beat: out_byte repeated repeat_count times;
//            last_of_run marks the final run of an input byte, stream_done
//            the final run of a message flush.
//   One byte is taken at a time: the accept step, a walk over its
//   context row (one count read a cycle), one divider load and 32
//   divide steps, the multiply steps, a carry step (a second when a
//   carry releases pending bytes), a normalize step per 0xFF byte and
//   a normalize step and the held-byte and pending emits per other
//   normalized byte, the range check, the model update and the finish
//   step. When a context total reaches 2^24, a sweep over the row and a
//   total write halve that row. The last byte of a message adds five
//   flush bytes and the tail steps. A run waits in a staging register
//   until the next run of its byte or the finish, then moves to the
//   output register; a stalled receiver holds the sequencer only when
//   both are full. Reset (and the end of every message) clears the row
//   valid bits, so the model starts fresh at once with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module order1_range_encoder (
	input logic        clk,
	input logic        arst_n,
	o1re_sym_if.sink   symbols,
	o1re_run_if.source runs
);
	import o1re_pkg::*;

	ctl_t ctl;
	sts_t sts;
	logic rdy;

	assign symbols.ready = rdy;

	o1re_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (symbols.valid),
		.in_ready (rdy),
		.sts      (sts),
		.ctl      (ctl)
	);

	o1re_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.data_byte      (symbols.data_byte),
		.end_of_message (symbols.end_of_message),
		.runs           (runs)
	);
endmodule
`default_nettype wire

### rtl/o1re_ctrl.sv
// Sequencer for the order-1 range encoder: steps one byte through walk,
// divide, code, normalize, model update, halving and flush. Uses o1re_pkg.
`timescale 1ns / 1ps
`default_nettype none
module o1re_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  o1re_pkg::sts_t sts,
	output o1re_pkg::ctl_t ctl
);
	import o1re_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_WALK, S_DIVI, S_DIV, S_MUL1, S_MUL2, S_CAR_A, S_CAR_B,
		S_NORM, S_EB_H, S_EB_P, S_INC, S_HALVE, S_HALVE_END, S_FLUSH,
		S_TAIL_H, S_TAIL_P, S_FIN
	} state_t;

	state_t              state_q, nxt;
	logic                flush_q, nxt_flush;
	logic [FCNT_W-1:0]   fcnt_q, nxt_fcnt;

	assign in_ready = (state_q == S_IDLE);

	// pick the operation and the next step
	always_comb begin
		nxt       = state_q;
		nxt_flush = flush_q;
		nxt_fcnt  = fcnt_q;
		ctl.op    = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.op    = OP_START;
					nxt       = S_WALK;
					nxt_flush = 1'b0;
					nxt_fcnt  = '0;
				end
			end
			S_WALK: begin
				ctl.op = OP_WALK;
				if (sts.sweep_last) nxt = S_DIVI;
			end
			S_DIVI: begin
				ctl.op = OP_DIV_INIT;
				nxt    = S_DIV;
			end
			S_DIV: begin
				ctl.op = OP_DIV_STEP;
				if (sts.div_last) nxt = S_MUL1;
			end
			S_MUL1: begin
				ctl.op = OP_MUL1;
				nxt    = S_MUL2;
			end
			S_MUL2: begin
				ctl.op = OP_MUL2;
				nxt    = S_CAR_A;
			end
			S_CAR_A: begin
				if (!sts.carry) begin
					nxt = S_NORM;
				end else if (!sts.pend_nz || sts.push_ok) begin
					ctl.op = OP_CARRY_A;
					nxt    = sts.pend_nz ? S_CAR_B : S_NORM;
				end
			end
			S_CAR_B: begin
				if (!sts.pend_gt1 || sts.push_ok) begin
					ctl.op = OP_CARRY_B;
					nxt    = S_NORM;
				end
			end
			S_NORM: begin
				if (!sts.range_small) begin
					nxt = S_INC;
				end else if (sts.top_ff) begin
					ctl.op = OP_NORM_FF;
				end else begin
					nxt = sts.held_v ? S_EB_H : S_EB_P;
				end
			end
			S_EB_H: begin
				if (sts.push_ok) begin
					ctl.op = OP_EMIT_H;
					nxt    = S_EB_P;
				end
			end
			S_EB_P: begin
				if (!(sts.held_v && sts.pend_nz) || sts.push_ok) begin
					ctl.op = OP_EMIT_P;
					if (!flush_q) begin
						nxt = S_NORM;
					end else if (fcnt_q == FCNT_W'(FLUSH_BYTES - 1)) begin
						nxt = S_TAIL_H;
					end else begin
						nxt_fcnt = fcnt_q + FCNT_W'(1);
						nxt      = S_FLUSH;
					end
				end
			end
			S_INC: begin
				ctl.op = OP_INC;
				if (sts.halve)    nxt = S_HALVE;
				else if (sts.eom) nxt = S_FLUSH;
				else              nxt = S_FIN;
			end
			S_HALVE: begin
				ctl.op = OP_HALVE;
				if (sts.sweep_last) nxt = S_HALVE_END;
			end
			S_HALVE_END: begin
				ctl.op = OP_HALVE_END;
				nxt    = sts.eom ? S_FLUSH : S_FIN;
			end
			S_FLUSH: begin
				nxt_flush = 1'b1;
				nxt       = sts.held_v ? S_EB_H : S_EB_P;
			end
			S_TAIL_H: begin
				if (!sts.held_v) begin
					nxt = S_FIN;
				end else if (sts.push_ok) begin
					ctl.op = OP_EMIT_H;
					nxt    = S_TAIL_P;
				end
			end
			S_TAIL_P: begin
				if (!sts.pend_nz || sts.push_ok) begin
					ctl.op = OP_TAIL;
					nxt    = S_FIN;
				end
			end
			S_FIN: begin
				if (sts.push_ok) begin
					ctl.op = OP_FINISH;
					nxt    = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			flush_q <= 1'b0;
			fcnt_q  <= '0;
		end else begin
			state_q <= nxt;
			flush_q <= nxt_flush;
			fcnt_q  <= nxt_fcnt;
		end
	end
endmodule
`default_nettype wire

### rtl/o1re_dp.sv
// Datapath of the order-1 range encoder: count memories, coder registers,
// divider, multipliers and the result staging. Uses o1re_pkg, o1re_run_if.
`timescale 1ns / 1ps
`default_nettype none
module o1re_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  o1re_pkg::ctl_t ctl,
	output o1re_pkg::sts_t sts,
	input  logic [7:0]     data_byte,
	input  logic           end_of_message,
	o1re_run_if.source     runs
);
	import o1re_pkg::*;

	// memories
	logic [CNT_W-1:0] cnt_mem [CONTEXTS*SYMBOLS];
	logic [CNT_W-1:0] tot_mem [CONTEXTS];
	logic [CNT_W-1:0] cnt_rd_s1, tot_rd_s1;
	logic [ADDR_W-1:0] cnt_raddr, cnt_waddr;
	logic              cnt_we, tot_we;
	logic [CNT_W-1:0]  cnt_wdata, tot_wdata;

	// item and coder state
	logic [SYM_BITS-1:0] sym_q;
	logic                eom_q;
	logic [CTX_BITS-1:0] ctx_q, prev_q;
	logic [CONTEXTS-1:0] rowv_q;
	logic [31:0]         low_q, range_q, pend_q;
	logic                held_v_q;
	logic [7:0]          held_q;
	logic [CNT_W-1:0]    cum_q, freq_q, tot_q, sum_q, rem_q;
	logic [31:0]         qd_q, r_q, prod_q;
	logic                carry_q;
	logic [4:0]          dcnt_q;
	logic [SYM_BITS:0]   idx_q;
	logic [SYM_BITS-1:0] idx_s1;
	logic                rd_v_s1;

	// result staging
	logic        stage_v_q, out_v_q, out_last_q, out_done_q;
	logic [7:0]  stage_byte_q, out_byte_q;
	logic [31:0] stage_cnt_q, out_cnt_q;

	logic              row_ok, sweeping, issue;
	logic [CNT_W-1:0]  walk_v, half_v, d_eff, rem_nxt;
	logic [CNT_W:0]    trial;
	logic              ge;
	logic [31:0]       r_eff, nrange, nlow;
	logic              push_en, move, taken, push_ok;
	logic [7:0]        push_byte;
	logic [31:0]       push_cnt;

	assign row_ok   = rowv_q[ctx_q];
	assign sweeping = (ctl.op == OP_WALK) || (ctl.op == OP_HALVE);
	assign issue    = sweeping && !idx_q[SYM_BITS];
	assign walk_v   = row_ok ? cnt_rd_s1 : CNT_ONE;
	assign half_v   = CNT_W'(({1'b0, cnt_rd_s1} + {{CNT_W{1'b0}}, 1'b1}) >> 1);
	assign cnt_raddr = {ctx_q, idx_q[SYM_BITS-1:0]};

	// divider step terms
	assign d_eff   = (tot_q == '0) ? CNT_ONE : tot_q;
	assign trial   = {rem_q, qd_q[31]};
	assign ge      = trial >= {1'b0, d_eff};
	assign rem_nxt = ge ? CNT_W'(trial - {1'b0, d_eff}) : CNT_W'(trial);
	assign r_eff   = (qd_q == '0) ? 32'd1 : qd_q;
	assign nrange  = 32'(freq_q) * r_q;
	assign nlow    = low_q + prod_q;

	// count and total memory write ports
	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = {ctx_q, idx_s1};
		cnt_wdata = CNT_ONE;
		tot_we    = 1'b0;
		tot_wdata = sum_q;
		case (ctl.op)
			OP_WALK: cnt_we = rd_v_s1 && !row_ok;
			OP_HALVE: begin
				cnt_we    = rd_v_s1;
				cnt_wdata = half_v;
			end
			OP_INC: begin
				cnt_we    = 1'b1;
				cnt_waddr = {ctx_q, sym_q};
				cnt_wdata = freq_q + CNT_ONE;
				tot_we    = 1'b1;
				tot_wdata = tot_q + CNT_ONE;
			end
			OP_HALVE_END: tot_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
		cnt_rd_s1 <= cnt_mem[cnt_raddr];
	end

	always_ff @(posedge clk) begin
		if (tot_we) tot_mem[ctx_q] <= tot_wdata;
		tot_rd_s1 <= tot_mem[ctx_q];
	end

	// choose the run to push
	always_comb begin
		push_en   = 1'b0;
		push_byte = BYTE_FF;
		push_cnt  = 32'd1;
		case (ctl.op)
			OP_CARRY_A: begin
				push_en   = (pend_q != '0);
				push_byte = held_v_q ? held_q + 8'd1 : BYTE_FF;
			end
			OP_CARRY_B: begin
				push_en   = (pend_q > 32'd1);
				push_byte = BYTE_00;
				push_cnt  = pend_q - 32'd1;
			end
			OP_EMIT_H: begin
				push_en   = 1'b1;
				push_byte = held_q;
			end
			OP_EMIT_P: begin
				push_en  = held_v_q && (pend_q != '0);
				push_cnt = pend_q;
			end
			OP_TAIL: begin
				push_en  = (pend_q != '0);
				push_cnt = pend_q;
			end
			default: ;
		endcase
	end

	assign taken   = out_v_q && runs.ready;
	assign push_ok = !stage_v_q || !out_v_q || runs.ready;
	assign move    = stage_v_q && (push_en || (ctl.op == OP_FINISH));

	// hold control and coder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rowv_q    <= '0;
			prev_q    <= '0;
			low_q     <= '0;
			range_q   <= WORD_FF;
			pend_q    <= '0;
			held_v_q  <= 1'b0;
			rd_v_s1   <= 1'b0;
			stage_v_q <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			if (move)       out_v_q <= 1'b1;
			else if (taken) out_v_q <= 1'b0;
			if (push_en)                    stage_v_q <= 1'b1;
			else if (ctl.op == OP_FINISH)   stage_v_q <= 1'b0;
			case (ctl.op)
				OP_DIV_INIT: rowv_q[ctx_q] <= 1'b1;
				OP_MUL2: begin
					low_q   <= nlow;
					range_q <= (nrange == '0) ? 32'd1 : nrange;
				end
				OP_CARRY_A: if (held_v_q) held_q <= held_q + 8'd1;
				OP_CARRY_B: begin
					held_v_q <= 1'b1;
					held_q   <= BYTE_00;
					pend_q   <= '0;
				end
				OP_NORM_FF: begin
					if (pend_q != WORD_FF) pend_q <= pend_q + 32'd1;
					low_q   <= {low_q[23:0], 8'h00};
					range_q <= {range_q[23:0], 8'h00};
				end
				OP_EMIT_P: begin
					if (held_v_q) pend_q <= '0;
					held_v_q <= 1'b1;
					held_q   <= low_q[31:24];
					low_q    <= {low_q[23:0], 8'h00};
					range_q  <= {range_q[23:0], 8'h00};
				end
				OP_INC: prev_q <= sym_q;
				OP_FINISH: begin
					if (eom_q) begin
						rowv_q   <= '0;
						prev_q   <= '0;
						low_q    <= '0;
						range_q  <= WORD_FF;
						pend_q   <= '0;
						held_v_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// advance payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[SYM_BITS-1:0];
		if (issue) idx_q <= idx_q + (SYM_BITS+1)'(1);
		if (push_en) begin
			stage_byte_q <= push_byte;
			stage_cnt_q  <= push_cnt;
		end
		if (move) begin
			out_byte_q <= stage_byte_q;
			out_cnt_q  <= stage_cnt_q;
			out_last_q <= (ctl.op == OP_FINISH);
			out_done_q <= (ctl.op == OP_FINISH) && eom_q;
		end
		case (ctl.op)
			OP_START: begin
				sym_q  <= data_byte;
				eom_q  <= end_of_message;
				ctx_q  <= prev_q;
				cum_q  <= '0;
				freq_q <= '0;
				idx_q  <= '0;
			end
			OP_WALK: begin
				if (rd_v_s1 && (idx_s1 < sym_q))  cum_q  <= cum_q + walk_v;
				if (rd_v_s1 && (idx_s1 == sym_q)) freq_q <= walk_v;
			end
			OP_DIV_INIT: begin
				tot_q  <= row_ok ? tot_rd_s1 : TOT_RESET;
				rem_q  <= '0;
				qd_q   <= range_q;
				dcnt_q <= '0;
			end
			OP_DIV_STEP: begin
				rem_q  <= rem_nxt;
				qd_q   <= {qd_q[30:0], ge};
				dcnt_q <= dcnt_q + 5'd1;
			end
			OP_MUL1: begin
				r_q    <= r_eff;
				prod_q <= 32'(cum_q) * r_eff;
			end
			OP_MUL2: carry_q <= (nlow < low_q);
			OP_INC: begin
				idx_q <= '0;
				sum_q <= '0;
			end
			OP_HALVE: if (rd_v_s1) sum_q <= sum_q + half_v;
			default: ;
		endcase
	end

	// status to the controller
	assign sts.sweep_last  = rd_v_s1 && (idx_s1 == SYM_BITS'(SYMBOLS - 1));
	assign sts.div_last    = (dcnt_q == 5'd31);
	assign sts.range_small = (range_q[31:24] == 8'h00);
	assign sts.top_ff      = (low_q[31:24] == BYTE_FF);
	assign sts.carry       = carry_q;
	assign sts.held_v      = held_v_q;
	assign sts.pend_nz     = (pend_q != '0);
	assign sts.pend_gt1    = (pend_q > 32'd1);
	assign sts.halve       = tot_q[CNT_W-1];
	assign sts.eom         = eom_q;
	assign sts.push_ok     = push_ok;

	assign runs.valid        = out_v_q;
	assign runs.out_byte     = out_byte_q;
	assign runs.repeat_count = out_cnt_q;
	assign runs.last_of_run  = out_last_q;
	assign runs.stream_done  = out_done_q;
endmodule
`default_nettype wire

### rtl/o1re_chk.sv
// Port-level checks for the order-1 range encoder, bound to the top level.
// Depends on order1_range_encoder.
`timescale 1ns / 1ps
`default_nettype none
module o1re_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] repeat_count,
	input logic        last_of_run,
	input logic        stream_done
);
	// a stalled beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// a run never has zero copies
	a_count_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> repeat_count != 32'd0)
		else $error("zero repeat count");

	// end of stream closes the byte's results
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_done |-> last_of_run)
		else $error("stream_done without last_of_run");

	// one byte at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("byte taken while busy");
endmodule

bind order1_range_encoder o1re_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (symbols.valid),
	.in_ready     (symbols.ready),
	.out_valid    (runs.valid),
	.out_ready    (runs.ready),
	.repeat_count (runs.repeat_count),
	.last_of_run  (runs.last_of_run),
	.stream_done  (runs.stream_done)
);
`default_nettype wire
